// ----- rtl/wnm_pkg.sv -----
// ============================================================================
// wnm_pkg: shared definitions for the wildcard name matcher
// Widths, character codes, register indexes and the lower-case fold used by
// the pattern store and the match datapath.
// ============================================================================
package wnm_pkg;

    localparam int STORED_CHARS        = 32;
    localparam int MAX_PATTERN_DEFAULT = 32;
    localparam int CHAR_W              = 8;
    localparam int LEN_W               = 6;
    localparam int CFG_DATA_W          = 64;
    localparam int CFG_INDEX_W         = 3;
    localparam int WORD_CHARS          = CFG_DATA_W / CHAR_W;

    localparam logic [CHAR_W-1:0] CHAR_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_QMARK   = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LENGTH  = 3'd0,
        REG_PATTERN_CHARS_0 = 3'd1,
        REG_PATTERN_CHARS_1 = 3'd2,
        REG_PATTERN_CHARS_2 = 3'd3,
        REG_PATTERN_CHARS_3 = 3'd4
    } cfg_reg_t;

    // Summary of the stored pattern handed to the match datapath.
    typedef struct packed {
        logic sub_mode;   // pattern holds no wildcard: substring search
        logic len_zero;   // empty pattern: every name matches
        logic restart;    // a register write happened this cycle
    } pat_info_t;

    // ASCII lower-case fold: only 'A' to 'Z' change.
    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ----- rtl/wnm_closure.sv -----
// ============================================================================
// wnm_closure: star closure over pattern positions
// Sets every position reachable from a set position through a run of '*'
// characters, as a parallel prefix of log2(W) levels, rounded up.
// ============================================================================
module wnm_closure #(
    parameter int W = 33
) (
    input  logic [W-1:0] v,
    input  logic [W-2:0] star,
    output logic [W-1:0] c
);

    localparam int LEVELS = $clog2(W);

    // Position j is reached from j-1 when pattern character j-1 is a star.
    logic [W-1:0] g [0:LEVELS];
    logic [W-1:0] p [0:LEVELS-1];

    assign g[0] = v;
    assign p[0] = {star, 1'b0};

    for (genvar lv = 0; lv < LEVELS; lv++)
    begin : g_level
        localparam int D = 1 << lv;
        for (genvar j = 0; j < W; j++)
        begin : g_bit
            if (j >= D)
            begin : g_span
                assign g[lv+1][j] = g[lv][j] | (p[lv][j] & g[lv][j-D]);
                if (lv < LEVELS - 1)
                begin : g_prop
                    assign p[lv+1][j] = p[lv][j] & p[lv][j-D];
                end
            end
            else
            begin : g_copy
                assign g[lv+1][j] = g[lv][j];
                if (lv < LEVELS - 1)
                begin : g_prop
                    assign p[lv+1][j] = p[lv][j];
                end
            end
        end
    end

    assign c = g[LEVELS];

endmodule

// ----- rtl/wnm_pattern.sv -----
// ============================================================================
// wnm_pattern: pattern registers and pattern decode
// Holds the configuration registers and derives the folded characters,
// wildcard masks, length masks and start positions of the pattern.
// ============================================================================
module wnm_pattern #(
    parameter int NUM_POS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [wnm_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [wnm_pkg::CFG_DATA_W-1:0]         cfg_data,
    output logic [NUM_POS-1:0][wnm_pkg::CHAR_W-1:0] pchar,
    output logic [NUM_POS-1:0]                     star,
    output logic [NUM_POS-1:0]                     qmark,
    output logic [NUM_POS-1:0]                     in_use,
    output logic [NUM_POS:0]                       len_onehot,
    output logic [NUM_POS:0]                       start_pos,
    output wnm_pkg::pat_info_t                     info
);

    localparam int WC = wnm_pkg::WORD_CHARS;

    logic [wnm_pkg::LEN_W-1:0]                              len_reg;
    logic [wnm_pkg::STORED_CHARS-1:0][wnm_pkg::CHAR_W-1:0]  char_reg;
    logic [wnm_pkg::LEN_W-1:0]                              used_len;
    logic                                                   valid_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            char_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (wnm_pkg::cfg_reg_t'(cfg_index))
                wnm_pkg::REG_PATTERN_LENGTH:
                    len_reg <= cfg_data[wnm_pkg::LEN_W-1:0];
                wnm_pkg::REG_PATTERN_CHARS_0: char_reg[0*WC +: WC] <= cfg_data;
                wnm_pkg::REG_PATTERN_CHARS_1: char_reg[1*WC +: WC] <= cfg_data;
                wnm_pkg::REG_PATTERN_CHARS_2: char_reg[2*WC +: WC] <= cfg_data;
                wnm_pkg::REG_PATTERN_CHARS_3: char_reg[3*WC +: WC] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (wnm_pkg::cfg_reg_t'(cfg_index))
            wnm_pkg::REG_PATTERN_LENGTH,
            wnm_pkg::REG_PATTERN_CHARS_0,
            wnm_pkg::REG_PATTERN_CHARS_1,
            wnm_pkg::REG_PATTERN_CHARS_2,
            wnm_pkg::REG_PATTERN_CHARS_3: valid_index = 1'b1;
            default:                      valid_index = 1'b0;
        endcase
    end

    // Length in use is saturated to the number of pattern positions.
    assign used_len = (len_reg > wnm_pkg::LEN_W'(NUM_POS)) ?
                      wnm_pkg::LEN_W'(NUM_POS) : len_reg;

    for (genvar i = 0; i < NUM_POS; i++)
    begin : g_char
        assign pchar[i]  = wnm_pkg::fold(char_reg[i]);
        assign in_use[i] = wnm_pkg::LEN_W'(i) < used_len;
        assign star[i]   = in_use[i] && (pchar[i] == wnm_pkg::CHAR_STAR);
        assign qmark[i]  = in_use[i] && (pchar[i] == wnm_pkg::CHAR_QMARK);
    end

    for (genvar k = 0; k <= NUM_POS; k++)
    begin : g_len
        assign len_onehot[k] = used_len == wnm_pkg::LEN_W'(k);
    end

    wnm_closure #(
        .W(NUM_POS + 1)
    ) u_start_closure (
        .v    ({{NUM_POS{1'b0}}, 1'b1}),
        .star (star),
        .c    (start_pos)
    );

    assign info.sub_mode = ~|(star | qmark);
    assign info.len_zero = len_onehot[0];
    assign info.restart  = cfg_we & valid_index;

endmodule

// ----- rtl/wildcard_name_matcher.sv -----
// ============================================================================
// wildcard_name_matcher: streaming case-insensitive wildcard name match
// Takes a name one character per transaction and reports, on the transaction
// that ends the name, whether it matches the stored pattern.
// ============================================================================
// The block accepts one character transaction in every clock cycle unless a
// name-ending transaction finds the result register full and not taken. A
// name's result is formed from the transaction in the input register and held
// in the result register. Each character runs the one-step update of the
// position vector, a shallow match-and-shift followed by a log-depth star
// closure. Both name and pattern are folded to lower case with ASCII rules.
// An empty pattern matches every name; a pattern without '*' or '?' matches
// when it occurs anywhere in the name; any other pattern is a full glob where
// '*' matches any run and '?' one character. Only end_of_name or empty_name
// transactions produce a result; empty_name wins over end_of_name and its
// text_char is ignored. A write to any defined configuration register
// restarts the name in progress with the new pattern. The user must write
// pattern registers only while idle; the block itself does not enforce it.
// ============================================================================
module wildcard_name_matcher #(
    parameter int MAX_PATTERN = wnm_pkg::MAX_PATTERN_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Character input channel.
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [wnm_pkg::CHAR_W-1:0]      text_char,
    input  logic                            end_of_name,
    input  logic                            empty_name,
    // Result output channel.
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            matched,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [wnm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wnm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Pattern positions in use: limited by the parameter and the storage.
    localparam int NUM_POS = (MAX_PATTERN < wnm_pkg::STORED_CHARS) ?
                             MAX_PATTERN : wnm_pkg::STORED_CHARS;

    // ------------------------------------------------------------------
    // Pattern store and decode.
    // ------------------------------------------------------------------
    logic [NUM_POS-1:0][wnm_pkg::CHAR_W-1:0] pchar;
    logic [NUM_POS-1:0]                     star;
    logic [NUM_POS-1:0]                     qmark;
    logic [NUM_POS-1:0]                     in_use;
    logic [NUM_POS:0]                       len_onehot;
    logic [NUM_POS:0]                       start_pos;
    wnm_pkg::pat_info_t                     info;

    wnm_pattern #(
        .NUM_POS(NUM_POS)
    ) u_pattern (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pchar      (pchar),
        .star       (star),
        .qmark      (qmark),
        .in_use     (in_use),
        .len_onehot (len_onehot),
        .start_pos  (start_pos),
        .info       (info)
    );

    // ------------------------------------------------------------------
    // Input register. It holds one transaction while its step runs.
    // ------------------------------------------------------------------
    logic                       s1_valid_reg;
    logic [wnm_pkg::CHAR_W-1:0] s1_char_reg;
    logic                       s1_end_reg;
    logic                       s1_empty_reg;
    logic                       s1_result;
    logic                       s1_fire;
    logic                       out_valid_reg;
    logic                       matched_reg;

    // The transaction in the input register produces a result when it ends
    // a name. It may move on unless that result would find the output
    // register still full and not being taken.
    assign s1_result = s1_end_reg | s1_empty_reg;
    assign s1_fire   = s1_valid_reg & (~s1_result | ~out_valid_reg | out_ready);
    assign in_ready  = ~s1_valid_reg | s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_char_reg  <= text_char;
            s1_end_reg   <= end_of_name;
            s1_empty_reg <= empty_name;
        end
    end

    // ------------------------------------------------------------------
    // Position vector. Bit i set means the first i pattern characters can
    // match the name so far. While fresh_reg is set the vector equals the
    // start positions of the current pattern, so a pattern write or a name
    // end needs no copy of the start vector.
    // ------------------------------------------------------------------
    logic [NUM_POS:0]           state_reg;
    logic                       fresh_reg;
    logic [NUM_POS:0]           cur;
    logic [wnm_pkg::CHAR_W-1:0] c_fold;
    logic [NUM_POS-1:0]         hit;
    logic [NUM_POS:0]           raw;
    logic [NUM_POS:0]           sub_keep;
    logic [NUM_POS:0]           closed;
    logic [NUM_POS:0]           adv;
    logic [NUM_POS:0]           final_pos;
    logic                       match_now;

    assign cur    = fresh_reg ? start_pos : state_reg;
    assign c_fold = wnm_pkg::fold(s1_char_reg);

    // A literal or '?' at a set position moves one place on; a '*' holds.
    for (genvar i = 0; i < NUM_POS; i++)
    begin : g_step
        assign hit[i] = cur[i] & in_use[i] & ~star[i] &
                        (qmark[i] | (pchar[i] == c_fold));
    end

    // In substring mode the search may begin at any character, and a
    // complete match stays set until the name ends.
    assign sub_keep = info.sub_mode ?
                      ((cur & len_onehot) | {{NUM_POS{1'b0}}, 1'b1}) : '0;
    assign raw      = {hit, 1'b0} | {1'b0, cur[NUM_POS-1:0] & star} | sub_keep;

    wnm_closure #(
        .W(NUM_POS + 1)
    ) u_step_closure (
        .v    (raw),
        .star (star),
        .c    (closed)
    );

    // Positions beyond the pattern length are never set.
    assign adv = closed & {in_use, 1'b1};

    // An empty name transaction carries no character, so the vector as it
    // stands decides the result.
    assign final_pos = s1_empty_reg ? cur : adv;
    assign match_now = info.len_zero | (|(final_pos & len_onehot));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= 1'b1;
        end
        else if (info.restart)
        begin
            fresh_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            fresh_reg <= s1_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && !s1_result)
        begin
            state_reg <= adv;
        end
    end

    // ------------------------------------------------------------------
    // Result register. It parts the output channel from the input side.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_result)
        begin
            matched_reg <= match_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

endmodule
